// ===== hw/rtl/utf8_stream_decoder_defines.svh =====
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define UTF8D_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder.
package utf8d_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int BYTE_W         = 8;
	localparam int CP_W           = 21;
	localparam int LEN_W          = 3;
	localparam int CNT_OUT_W      = 16;
	localparam int TDATA_W        = 40;
	localparam int TUSER_W        = 2;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// One result item
	typedef struct packed {
		kind_t                  kind;
		logic [CP_W-1:0]        code_point;
		logic [LEN_W-1:0]       seq_len;
		logic [CNT_OUT_W-1:0]   char_count;
	} res_t;

endpackage

// ===== hw/rtl/utf8d_core.sv =====
// Decoder state and the per-byte update that forms one result.
module utf8d_core #(
	parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,       // consume data_byte this cycle
	input  logic [utf8d_pkg::BYTE_W-1:0]  data_byte,
	output logic                          res_valid,  // step yields a result
	output utf8d_pkg::res_t               res
);
	import utf8d_pkg::*;

	logic [CP_W-1:0]       accum_q,      accum_d;
	logic [1:0]            bytes_left_q, bytes_left_d;
	logic [LEN_W-1:0]      cur_len_q,    cur_len_d;
	logic [COUNT_BITS-1:0] count_q,      count_d;
	logic                  discarding_q, discarding_d;

	logic [COUNT_BITS-1:0] count_inc;
	logic [CP_W-1:0]       accum_shift;

	// Low bits of the count as reported on the result
	function automatic logic [CNT_OUT_W-1:0] report_cnt(input logic [COUNT_BITS-1:0] c);
		logic [31:0] ext;
		ext = 32'(c);
		return ext[CNT_OUT_W-1:0];
	endfunction

	// Saturating increment and continuation shift
	assign count_inc   = (count_q == '1) ? count_q : count_q + 1'b1;
	assign accum_shift = {accum_q[CP_W-7:0], data_byte[5:0]};

	// Next state and result for the byte
	always_comb begin
		accum_d        = accum_q;
		bytes_left_d   = bytes_left_q;
		cur_len_d      = cur_len_q;
		count_d        = count_q;
		discarding_d   = discarding_q;
		res_valid      = 1'b0;
		res.kind       = KIND_ERR;
		res.code_point = '0;
		res.seq_len    = '0;
		res.char_count = report_cnt(count_q);

		if (discarding_q) begin
			// skip to the next NUL, which restarts the string
			if (data_byte == '0) begin
				discarding_d = 1'b0;
				count_d      = '0;
			end
		end else if (bytes_left_q == 2'd0) begin
			// lead position
			if (data_byte == '0) begin
				res_valid = 1'b1;
				res.kind  = KIND_END;
				count_d   = '0;
			end else if (data_byte inside {[8'h01:8'h7F]}) begin
				res_valid      = 1'b1;
				res.kind       = KIND_CHAR;
				res.code_point = CP_W'(data_byte);
				res.seq_len    = LEN_W'(1);
				res.char_count = report_cnt(count_inc);
				count_d        = count_inc;
			end else if (data_byte inside {[8'hC0:8'hDF]}) begin
				accum_d      = CP_W'(data_byte[4:0]);
				bytes_left_d = 2'd1;
				cur_len_d    = LEN_W'(2);
			end else if (data_byte inside {[8'hE0:8'hEF]}) begin
				accum_d      = CP_W'(data_byte[3:0]);
				bytes_left_d = 2'd2;
				cur_len_d    = LEN_W'(3);
			end else if (data_byte inside {[8'hF0:8'hF7]}) begin
				accum_d      = CP_W'(data_byte[2:0]);
				bytes_left_d = 2'd3;
				cur_len_d    = LEN_W'(4);
			end else begin
				res_valid    = 1'b1;
				discarding_d = 1'b1;
			end
		end else if (data_byte[7:6] != 2'b10) begin
			// broken sequence; a NUL here also ends the string
			res_valid    = 1'b1;
			accum_d      = '0;
			bytes_left_d = 2'd0;
			cur_len_d    = '0;
			if (data_byte == '0)
				count_d = '0;
			else
				discarding_d = 1'b1;
		end else if (bytes_left_q == 2'd1) begin
			// last continuation byte completes the character
			res_valid      = 1'b1;
			res.kind       = KIND_CHAR;
			res.code_point = accum_shift;
			res.seq_len    = cur_len_q;
			res.char_count = report_cnt(count_inc);
			count_d        = count_inc;
			accum_d        = '0;
			bytes_left_d   = 2'd0;
			cur_len_d      = '0;
		end else begin
			accum_d      = accum_shift;
			bytes_left_d = bytes_left_q - 2'd1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= '0;
			bytes_left_q <= 2'd0;
			cur_len_q    <= '0;
			count_q      <= '0;
			discarding_q <= 1'b0;
		end else if (step) begin
			accum_q      <= accum_d;
			bytes_left_q <= bytes_left_d;
			cur_len_q    <= cur_len_d;
			count_q      <= count_d;
			discarding_q <= discarding_d;
		end
	end

endmodule

// ===== hw/rtl/utf8d_out_reg.sv =====
// Result register driving the master-side stream.
module utf8d_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,          // load a new result
	input  utf8d_pkg::res_t                res,
	output logic                           can_load,      // register free this cycle
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// code_point[20:0], seq_len[23:21], char_count[39:24]
	output logic [utf8d_pkg::TDATA_W-1:0]  m_axis_tdata,
	// kind[1:0]
	output logic [utf8d_pkg::TUSER_W-1:0]  m_axis_tuser
);
	import utf8d_pkg::*;

	logic valid_q;
	res_t res_q;

	// Free when empty or being drained this cycle
	assign can_load = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && push) begin
			res_q <= res;
		end
	end

	// Pack the result onto the bus
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {res_q.char_count, res_q.seq_len, res_q.code_point};
	assign m_axis_tuser  = res_q.kind;

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// Top level of the byte-serial UTF-8 stream decoder.
//
//   channel   | dir | tdata (low bit up)                          | tuser
//   s_axis    | in  | data_byte[7:0]                              | -
//   m_axis    | out | code_point[20:0] seq_len[23:21] cnt[39:24]  | kind[1:0]
//
// One byte per cycle while the output is not stalled: a byte waits in the input
// register, is decoded there against the state, and its result (if any) lands in
// the output register.
// Reset clears the decoder state and both valid flags; no clearing pass.
// A stalled output stops the input register only when it is full; ready falls
// then and the current byte waits in place.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder #(
	parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// data_byte[7:0]
	input  logic [utf8d_pkg::BYTE_W-1:0]   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// code_point[20:0], seq_len[23:21], char_count[39:24]
	output logic [utf8d_pkg::TDATA_W-1:0]  m_axis_tdata,
	// kind[1:0]
	output logic [utf8d_pkg::TUSER_W-1:0]  m_axis_tuser
);
	import utf8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              can_load;
	logic              step;
	logic              res_valid;
	res_t              res;

	// Byte in the input register is decoded when the output can take its result
	assign step          = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	utf8d_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	utf8d_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (step && res_valid),
		.res           (res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// End and error results carry no character
	`UTF8D_ASSERT_IMPL(a_noncar_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser != KIND_CHAR, m_axis_tdata[23:0] == '0, "end/error result with nonzero code point or length")
	// Characters are one to four bytes long
	`UTF8D_ASSERT_IMPL(a_char_len, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_CHAR, m_axis_tdata[23:21] == 3'd1 || m_axis_tdata[23:21] == 3'd2 || m_axis_tdata[23:21] == 3'd3 || m_axis_tdata[23:21] == 3'd4, "character result with bad length")
	// An empty output register never holds back a pending byte
	`UTF8D_ASSERT_IMPL(a_no_bubble, clk, arst_n, valid_s1 && !m_axis_tvalid, s_axis_tready, "input stalled while output is empty")
	// A result appears only after a decoded byte
	`UTF8D_ASSERT_NEXT(a_res_src, clk, arst_n, !step && !m_axis_tvalid, !m_axis_tvalid, "result without a decoded byte")

endmodule
